### src/skls_pkg.sv
// ---------------------------------------------------------------------------
// skls_pkg
// Shared types and constants for the sorted key set on a linked node pool.
// ---------------------------------------------------------------------------
package skls_pkg;

  localparam int OP_W  = 2;
  localparam int KEY_W = 32;

  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE   = 2'd2;
  localparam logic [OP_W-1:0] OP_CONTAINS = 2'd3;

  // all-ones key is reserved and never enters the set
  localparam logic [KEY_W-1:0] RESERVED_KEY = {KEY_W{1'b1}};

  // finished answer handed from the sequencer to the output stage
  typedef struct packed {
    logic valid;
    logic ok;
  } skls_res_t;

  // write enables of the node store, one per field
  typedef struct packed {
    logic key_we;
    logic link_we;
  } skls_wen_t;

endpackage

### src/skls_ifs.sv
// ---------------------------------------------------------------------------
// skls_req_if / skls_rsp_if
// Valid/ready channels for operations in and answers out.
// ---------------------------------------------------------------------------
interface skls_req_if import skls_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [KEY_W-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

interface skls_rsp_if;
  logic valid;
  logic ready;
  logic ok;

  modport source (output valid, output ok, input ready);
  modport sink   (input valid, input ok, output ready);
endinterface

### src/skls_node_store.sv
// ---------------------------------------------------------------------------
// skls_node_store
// Node key and link memories: one write port with per-field enables, one
// registered read port.
// ---------------------------------------------------------------------------
module skls_node_store import skls_pkg::*; #(
  parameter int POOL_NODES = 256
) (
  input  logic                                  clk,
  input  logic                                  rd_en,
  input  logic [$clog2(POOL_NODES)-1:0]         rd_addr,
  output logic [KEY_W-1:0]                      rd_key,
  output logic [$clog2(POOL_NODES+1)-1:0]       rd_link,
  input  skls_wen_t                             wr_en,
  input  logic [$clog2(POOL_NODES)-1:0]         wr_addr,
  input  logic [KEY_W-1:0]                      wr_key,
  input  logic [$clog2(POOL_NODES+1)-1:0]       wr_link
);

  localparam int IW = $clog2(POOL_NODES + 1);

  logic [KEY_W-1:0] key_mem  [POOL_NODES];
  logic [IW-1:0]    link_mem [POOL_NODES];

  always_ff @(posedge clk) begin
    if (wr_en.key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (wr_en.link_we) begin
      link_mem[wr_addr] <= wr_link;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key  <= key_mem[rd_addr];
      rd_link <= link_mem[rd_addr];
    end
  end

endmodule

### src/skls_seq.sv
// ---------------------------------------------------------------------------
// skls_seq
// Operation sequencer: walks the list one node per cycle through the shared
// key compare, then pops or allocates, relinks and frees nodes.
// ---------------------------------------------------------------------------
module skls_seq import skls_pkg::*; #(
  parameter int POOL_NODES = 256
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [OP_W-1:0]                       op,
  input  logic [KEY_W-1:0]                      key,
  output logic                                  idle,
  output skls_res_t                             res,
  input  logic                                  res_free,
  output logic                                  rd_en,
  output logic [$clog2(POOL_NODES)-1:0]         rd_addr,
  input  logic [KEY_W-1:0]                      rd_key,
  input  logic [$clog2(POOL_NODES+1)-1:0]       rd_link,
  output skls_wen_t                             wr_en,
  output logic [$clog2(POOL_NODES)-1:0]         wr_addr,
  output logic [KEY_W-1:0]                      wr_key,
  output logic [$clog2(POOL_NODES+1)-1:0]       wr_link
);

  localparam int AW = $clog2(POOL_NODES);
  localparam int IW = $clog2(POOL_NODES + 1);
  localparam logic [IW-1:0] NIL = IW'(POOL_NODES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEEK   = 3'd1;
  localparam logic [2:0] S_ACT    = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_LINK   = 3'd4;
  localparam logic [2:0] S_FREE   = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0]       state, state_next;
  logic [IW-1:0]    list_first, list_first_next;
  logic [IW-1:0]    free_first, free_first_next;
  logic [IW-1:0]    fresh_count, fresh_count_next;

  logic [OP_W-1:0]  item_op, item_op_next;
  logic [KEY_W-1:0] item_key, item_key_next;
  logic [IW-1:0]    prev, prev_next;
  logic [IW-1:0]    cur, cur_next;
  logic [IW-1:0]    cur_link, cur_link_next;
  logic [IW-1:0]    alloc_node, alloc_node_next;
  logic             hit, hit_next;
  logic             ok, ok_next;

  logic             key_lt;
  logic             key_eq;

  // shared compare unit
  assign key_lt = rd_key < item_key;
  assign key_eq = rd_key == item_key;

  assign idle      = state == S_IDLE;
  assign res.valid = state == S_RESULT;
  assign res.ok    = ok;

  always_comb begin
    state_next       = state;
    list_first_next  = list_first;
    free_first_next  = free_first;
    fresh_count_next = fresh_count;
    item_op_next     = item_op;
    item_key_next    = item_key;
    prev_next        = prev;
    cur_next         = cur;
    cur_link_next    = cur_link;
    alloc_node_next  = alloc_node;
    hit_next         = hit;
    ok_next          = ok;
    rd_en            = 1'b0;
    rd_addr          = cur[AW-1:0];
    wr_en            = '0;
    wr_addr          = prev[AW-1:0];
    wr_key           = item_key;
    wr_link          = cur;

    case (state)
      S_IDLE: begin
        if (start) begin
          item_op_next  = op;
          item_key_next = key;
          if (op == OP_CLEAR) begin
            list_first_next  = NIL;
            free_first_next  = NIL;
            fresh_count_next = '0;
            ok_next          = 1'b0;
            state_next       = S_RESULT;
          end else if (key == RESERVED_KEY) begin
            ok_next    = 1'b0;
            state_next = S_RESULT;
          end else begin
            prev_next  = NIL;
            cur_next   = list_first;
            rd_en      = list_first < NIL;
            rd_addr    = list_first[AW-1:0];
            state_next = S_SEEK;
          end
        end
      end

      S_SEEK: begin
        if (cur >= NIL) begin
          hit_next   = 1'b0;
          state_next = S_ACT;
        end else if (key_lt) begin
          // advance and fetch the next node in the same cycle
          prev_next = cur;
          cur_next  = rd_link;
          rd_en     = rd_link < NIL;
          rd_addr   = rd_link[AW-1:0];
        end else begin
          hit_next      = key_eq;
          cur_link_next = rd_link;
          state_next    = S_ACT;
        end
      end

      S_ACT: begin
        case (item_op)
          OP_CONTAINS: begin
            ok_next    = hit;
            state_next = S_RESULT;
          end
          OP_ADD: begin
            if (hit) begin
              ok_next    = 1'b0;
              state_next = S_RESULT;
            end else if (free_first < NIL) begin
              rd_en      = 1'b1;
              rd_addr    = free_first[AW-1:0];
              state_next = S_POP;
            end else if (fresh_count < NIL) begin
              alloc_node_next  = fresh_count;
              fresh_count_next = fresh_count + 1'b1;
              wr_en            = '{key_we: 1'b1, link_we: 1'b1};
              wr_addr          = fresh_count[AW-1:0];
              wr_link          = cur;
              state_next       = S_LINK;
            end else begin
              ok_next    = 1'b0;
              state_next = S_RESULT;
            end
          end
          OP_REMOVE: begin
            if (!hit) begin
              ok_next    = 1'b0;
              state_next = S_RESULT;
            end else begin
              // unlink: predecessor skips over the hit node
              if (prev < NIL) begin
                wr_en   = '{key_we: 1'b0, link_we: 1'b1};
                wr_addr = prev[AW-1:0];
                wr_link = cur_link;
              end else begin
                list_first_next = cur_link;
              end
              state_next = S_FREE;
            end
          end
          default: begin
            ok_next    = 1'b0;
            state_next = S_RESULT;
          end
        endcase
      end

      S_POP: begin
        alloc_node_next = free_first;
        free_first_next = rd_link;
        wr_en           = '{key_we: 1'b1, link_we: 1'b1};
        wr_addr         = free_first[AW-1:0];
        wr_link         = cur;
        state_next      = S_LINK;
      end

      S_LINK: begin
        if (prev < NIL) begin
          wr_en   = '{key_we: 1'b0, link_we: 1'b1};
          wr_addr = prev[AW-1:0];
          wr_link = alloc_node;
        end else begin
          list_first_next = alloc_node;
        end
        ok_next    = 1'b1;
        state_next = S_RESULT;
      end

      S_FREE: begin
        // push the removed node on the free stack
        wr_en           = '{key_we: 1'b0, link_we: 1'b1};
        wr_addr         = cur[AW-1:0];
        wr_link         = free_first;
        free_first_next = cur;
        ok_next         = 1'b1;
        state_next      = S_RESULT;
      end

      S_RESULT: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      list_first  <= NIL;
      free_first  <= NIL;
      fresh_count <= '0;
    end else begin
      state       <= state_next;
      list_first  <= list_first_next;
      free_first  <= free_first_next;
      fresh_count <= fresh_count_next;
    end
  end

  always_ff @(posedge clk) begin
    item_op    <= item_op_next;
    item_key   <= item_key_next;
    prev       <= prev_next;
    cur        <= cur_next;
    cur_link   <= cur_link_next;
    alloc_node <= alloc_node_next;
    hit        <= hit_next;
    ok         <= ok_next;
  end

endmodule

### src/sorted_key_set_linked_pool_core.sv
// ---------------------------------------------------------------------------
// sorted_key_set_linked_pool_core
// Sorted set of 32-bit keys kept as an ascending linked list in a node pool.
// ---------------------------------------------------------------------------
// Each request (clear, add, remove, contains) returns one ok answer. The
// block takes one request at a time: a request walks the list through the
// node store's single read port, one node per cycle; then contains, a miss
// of remove or a hit of add answers, remove unlinks and frees the node, and
// add pops a freed node or takes a fresh one and links it in. Clear and the
// reserved all-ones key skip the walk. The answer sits in an output
// register, so the next request is taken while it waits. Removed nodes
// are reused last-freed first; never-used nodes are handed out in index
// order. No clearing pass runs after reset.
module sorted_key_set_linked_pool_core import skls_pkg::*; #(
  parameter int POOL_NODES = 256
) (
  input  logic       clk,
  input  logic       rst,
  skls_req_if.sink   req,
  skls_rsp_if.source rsp
);

  localparam int AW = $clog2(POOL_NODES);
  localparam int IW = $clog2(POOL_NODES + 1);

  logic             idle;
  logic             start;
  logic             slot_free;
  skls_res_t        res;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [KEY_W-1:0] rd_key;
  logic [IW-1:0]    rd_link;
  skls_wen_t        wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_key;
  logic [IW-1:0]    wr_link;
  logic             out_valid;
  logic             out_ok;

  assign req.ready = idle;
  assign start     = req.valid && idle;
  assign slot_free = !out_valid || rsp.ready;

  skls_seq #(
    .POOL_NODES (POOL_NODES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .op       (req.op),
    .key      (req.key),
    .idle     (idle),
    .res      (res),
    .res_free (slot_free),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_link  (rd_link),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_link  (wr_link)
  );

  skls_node_store #(
    .POOL_NODES (POOL_NODES)
  ) u_node_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_link (rd_link),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_link (wr_link)
  );

  // output register: load a finished answer when the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res.valid) begin
      out_ok <= res.ok;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.ok    = out_ok;

endmodule

### test/sorted_key_set_linked_pool_core_tb.sv
// ---------------------------------------------------------------------------
// sorted_key_set_linked_pool_core_tb
// Self-checking bench for the sorted key set kept on a linked node pool.
// Add, remove, contains and clear transactions are sent with random gaps.
// A behavioral copy of the list, the freed-node stack and the fresh-node
// counter predicts every ok answer. Answers are taken under random
// back-pressure and compared in order against the predicted answers.
// ---------------------------------------------------------------------------
module sorted_key_set_linked_pool_core_tb import skls_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL = 256;
  localparam int NIL  = POOL;

  logic clk;
  logic rst;

  skls_req_if req_ch ();
  skls_rsp_if rsp_ch ();

  sorted_key_set_linked_pool_core #(
    .POOL_NODES(POOL)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // behavioral copy of the set
  logic [KEY_W-1:0] pool_key  [POOL];
  int               pool_link [POOL];
  int               head_idx;
  int               free_top;
  int               fresh_next;

  logic pending_ok [$];
  int   fail_count;
  bit   gaps_on;
  logic want_ok;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Apply one transaction to the set copy and return the expected answer.
  function automatic logic set_answer(input logic [OP_W-1:0] op,
                                      input logic [KEY_W-1:0] key);
    int   prv;
    int   cur;
    int   nxt;
    int   steps;
    int   n;
    logic hit;
    if (op == OP_CLEAR) begin
      head_idx   = NIL;
      free_top   = NIL;
      fresh_next = 0;
      return 1'b0;
    end
    if (key == RESERVED_KEY) return 1'b0;
    prv   = NIL;
    cur   = head_idx;
    steps = 0;
    while (cur < POOL && steps < POOL && pool_key[cur] < key) begin
      prv = cur;
      cur = pool_link[cur];
      steps++;
    end
    if (cur >= POOL) cur = NIL;
    hit = (cur != NIL) && (pool_key[cur] == key);
    case (op)
      OP_ADD: begin
        if (hit) return 1'b0;
        // reuse the last freed node first, then a never-used one
        if (free_top != NIL) begin
          n        = free_top;
          free_top = (pool_link[n] < POOL) ? pool_link[n] : NIL;
        end else if (fresh_next < POOL) begin
          n = fresh_next;
          fresh_next++;
        end else begin
          return 1'b0;
        end
        pool_key[n]  = key;
        pool_link[n] = cur;
        if (prv == NIL) head_idx = n;
        else pool_link[prv] = n;
        return 1'b1;
      end
      OP_REMOVE: begin
        if (!hit) return 1'b0;
        nxt = (pool_link[cur] < POOL) ? pool_link[cur] : NIL;
        if (prv == NIL) head_idx = nxt;
        else pool_link[prv] = nxt;
        pool_link[cur] = free_top;
        free_top       = cur;
        return 1'b1;
      end
      default: return hit;
    endcase
  endfunction

  // Send one transaction; returns at the falling edge after acceptance with
  // valid still high, so a following send keeps the channel busy.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    while (gaps_on && $urandom_range(99) < 31) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.key   <= key;
    do @(posedge clk); while (!req_ch.ready);
    pending_ok.push_back(set_answer(op, key));
    @(negedge clk);
  endtask

  // Drop valid and hold until every outstanding answer is back.
  task automatic hold_until_answered();
    req_ch.valid <= 1'b0;
    while (pending_ok.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return {4'($urandom_range(15)), 26'd0, 2'($urandom_range(3))};
    if (r < 85) return $urandom();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 32'hFFFF_FFFE;
      2:       return RESERVED_KEY;
      3:       return 32'h8000_0000;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 2)  return OP_CLEAR;
    if (r < 45) return OP_ADD;
    if (r < 70) return OP_REMOVE;
    return OP_CONTAINS;
  endfunction

  task automatic test_directed();
    send_op(OP_CONTAINS, 32'h0000_0000);
    send_op(OP_REMOVE,   32'h0000_0005);
    send_op(OP_ADD,      32'h0000_0000);
    send_op(OP_CONTAINS, 32'h0000_0000);
    send_op(OP_ADD,      32'h0000_0000);
    // reserved key changes nothing
    send_op(OP_ADD,      RESERVED_KEY);
    send_op(OP_CONTAINS, RESERVED_KEY);
    send_op(OP_REMOVE,   RESERVED_KEY);
    send_op(OP_ADD,      32'hFFFF_FFFE);
    send_op(OP_ADD,      32'h8000_0000);
    send_op(OP_ADD,      32'h0000_0001);
    send_op(OP_CONTAINS, 32'hFFFF_FFFE);
    send_op(OP_REMOVE,   32'h8000_0000);
    send_op(OP_REMOVE,   32'h8000_0000);
    send_op(OP_ADD,      32'h7FFF_FFFF);
    send_op(OP_CONTAINS, 32'h8000_0000);
    send_op(OP_CONTAINS, 32'h7FFF_FFFF);
    send_op(OP_CLEAR,    RESERVED_KEY);
    send_op(OP_CONTAINS, 32'h0000_0000);
    send_op(OP_ADD,      32'h0000_0005);
    send_op(OP_REMOVE,   32'h0000_0005);
    send_op(OP_CONTAINS, 32'h0000_0005);
    send_op(OP_CLEAR,    32'h0000_0000);
  endtask

  task automatic test_pool_full();
    // descending keys insert at the head, keeping each walk short
    for (int i = 0; i < POOL; i++) send_op(OP_ADD, (POOL - i) * 32'h0010_0000);
    send_op(OP_ADD,      32'h0000_0000);
    send_op(OP_ADD,      32'hFFFF_FFFE);
    send_op(OP_REMOVE,   32'h0080_0000);
    send_op(OP_REMOVE,   32'h0010_0000);
    send_op(OP_ADD,      32'h0010_0001);
    send_op(OP_ADD,      32'h0080_0000);
    send_op(OP_ADD,      32'h0000_0005);
    send_op(OP_CONTAINS, 32'h1000_0000);
    send_op(OP_CONTAINS, 32'h0010_0001);
    send_op(OP_CLEAR,    32'h0000_0000);
    send_op(OP_CONTAINS, 32'h0010_0000);
    send_op(OP_ADD,      32'h0000_0007);
    send_op(OP_CONTAINS, 32'h0000_0007);
  endtask

  task automatic test_random();
    for (int i = 0; i < 1000; i++) begin
      gaps_on = !(i >= 400 && i < 650);
      if (i == 800) hold_until_answered();
      send_op(pick_op(), pick_key());
    end
    gaps_on = 1'b1;
  endtask

  // answer channel back-pressure
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready <= !(gaps_on && $urandom_range(99) < 31);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_ok.size() == 0) begin
        $error("ok: expected none, actual %0d", rsp_ch.ok);
        fail_count++;
      end else begin
        want_ok = pending_ok.pop_front();
        if (rsp_ch.ok !== want_ok) begin
          $error("ok: expected %0d, actual %0d", want_ok, rsp_ch.ok);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int waited;
    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op    = OP_CLEAR;
    req_ch.key   = '0;
    gaps_on      = 1'b1;
    fail_count   = 0;
    head_idx     = NIL;
    free_top     = NIL;
    fresh_next   = 0;
    for (int i = 0; i < POOL; i++) begin
      pool_key[i]  = '0;
      pool_link[i] = 0;
    end
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    hold_until_answered();
    test_pool_full();
    hold_until_answered();
    test_random();

    req_ch.valid <= 1'b0;
    waited = 0;
    while (pending_ok.size() != 0 && waited < 100_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (POOL + 8) @(posedge clk);
    if (pending_ok.size() != 0) begin
      $error("ok: expected %0d more answers, actual none", pending_ok.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
